FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define ASSERT_IMPLY(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while dis is high.
`define ASSERT_NEXT(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/blsp_pkg.sv
`default_nettype none

package blsp_pkg;

  // Default coordinate width.
  localparam int COORD_BITS_DEFAULT = 12;

  // Entries in the queue between the front and back parts (power of two).
  localparam int QUEUE_DEPTH = 2;

  // Item operation codes.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

endpackage

`default_nettype wire

FILE: hdl/blsp_front.sv
`default_nettype none

module blsp_front #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                  operation,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  output blsp_pkg::op_t              op,
  output logic      [COORD_BITS-1:0] dist_x,
  output logic      [COORD_BITS-1:0] dist_y,
  output logic                       x_neg,
  output logic                       y_neg
);

  // Classify the item.
  assign op = blsp_pkg::op_t'(operation);

  // Take axis directions; a zero difference steps upward.
  assign x_neg = end_x < start_x;
  assign y_neg = end_y < start_y;

  // Take absolute axis distances.
  assign dist_x = x_neg ? (start_x - end_x) : (end_x - start_x);
  assign dist_y = y_neg ? (start_y - end_y) : (end_y - start_y);

endmodule

`default_nettype wire

FILE: hdl/blsp_queue.sv
`default_nettype none

module blsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = blsp_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_wr;
  logic do_rd;

  assign full     = count == CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Store an incoming item.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and track the fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/blsp_back.sv
`default_nettype none

module blsp_back #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // queue side
  input  wire logic                  q_valid,
  input  wire blsp_pkg::op_t         q_op,
  input  wire logic [COORD_BITS-1:0] q_start_x,
  input  wire logic [COORD_BITS-1:0] q_start_y,
  input  wire logic [COORD_BITS-1:0] q_dist_x,
  input  wire logic [COORD_BITS-1:0] q_dist_y,
  input  wire logic                  q_x_neg,
  input  wire logic                  q_y_neg,
  output logic                       q_pop,
  // result side
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [COORD_BITS-1:0] pixel_x,
  output logic      [COORD_BITS-1:0] pixel_y,
  output logic                       last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int EW = CB + 3;

  // Line state
  logic [CB-1:0] cur_x;
  logic [CB-1:0] cur_y;
  logic [CB-1:0] remaining;
  logic [EW-1:0] error_term;
  logic [CB:0]   inc_minor;
  logic [CB+1:0] inc_both;
  logic          step_x_neg;
  logic          step_y_neg;
  logic          axes_swapped;
  logic          out_valid;

  // Load setup
  logic          swap_ld;
  logic [CB-1:0] major_ld;
  logic [CB-1:0] minor_ld;

  // Step decisions
  logic          err_pos;
  logic          move_x;
  logic          move_y;
  logic [CB-1:0] cur_x_next;
  logic [CB-1:0] cur_y_next;
  logic [EW-1:0] error_term_next;

  logic          emit_ok;
  logic          live;
  logic          is_step;
  logic          do_load;
  logic          do_step;

  // Pick the major axis for a new line.
  assign swap_ld  = q_dist_y > q_dist_x;
  assign major_ld = swap_ld ? q_dist_y : q_dist_x;
  assign minor_ld = swap_ld ? q_dist_x : q_dist_y;

  // Decide the minor move and the next error term.
  assign err_pos         = !error_term[EW-1] && (error_term != '0);
  assign move_x          = axes_swapped ? err_pos : 1'b1;
  assign move_y          = axes_swapped ? 1'b1 : err_pos;
  assign cur_x_next      = move_x ? (step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1) : cur_x;
  assign cur_y_next      = move_y ? (step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1) : cur_y;
  assign error_term_next = error_term + (err_pos ? {inc_both[CB+1], inc_both}
                                                 : {2'b00, inc_minor});

  // Pop the queue when the item can be carried out; idle steps are dropped.
  assign emit_ok = !out_valid || pop;
  assign live    = remaining != '0;
  assign is_step = q_op == blsp_pkg::OP_STEP;
  assign q_pop   = q_valid && (!is_step || !live || emit_ok);
  assign do_load = q_pop && !is_step;
  assign do_step = q_pop && is_step && live;

  // Hold the line state.
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (do_load) begin
      remaining <= major_ld;
    end else if (do_step) begin
      remaining <= remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      cur_x        <= q_start_x;
      cur_y        <= q_start_y;
      step_x_neg   <= q_x_neg;
      step_y_neg   <= q_y_neg;
      axes_swapped <= swap_ld;
      error_term   <= {2'b00, minor_ld, 1'b0} - {3'b000, major_ld};
      inc_minor    <= {minor_ld, 1'b0};
      inc_both     <= {1'b0, minor_ld, 1'b0} - {1'b0, major_ld, 1'b0};
    end else if (do_step) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_term_next;
    end
  end

  // Hold the result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_step) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      pixel_x    <= cur_x;
      pixel_y    <= cur_y;
      last_pixel <= remaining == CB'(1);
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: hdl/bresenham_line_stepper.sv
// All-octant Bresenham line stepper.
// Input channel (push/full): an item is taken when push is high and full is
// low. operation OP_LOAD latches a line from (start_x,start_y) to
// (end_x,end_y) and gives no result; OP_STEP gives the next pixel of the line.
// A line yields as many pixels as its major-axis distance: the start point is
// included, the end point is not, and the final pixel has last_pixel set.
// A step with no line in progress gives nothing; a load replaces any line.
// Result channel (empty/pop): the oldest pixel is on pixel_x/pixel_y/
// last_pixel while empty is low and is taken when pop is high.
// A step item passes through the queue and then the result register.
// Throughput: one item per cycle while the results are taken; the front
// computes axis distances, a two-entry queue decouples it from the back,
// whose error-term add and coordinate increments finish one step per cycle.
// When pop stays low the result register holds; the queue then fills and
// full rises two items later. Reset empties the queue and the result register
// and leaves no line in progress.
`default_nettype none

module bresenham_line_stepper #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  operation,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [COORD_BITS-1:0] pixel_x,
  output logic      [COORD_BITS-1:0] pixel_y,
  output logic                       last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int QW = 1 + 4 * CB + 2;

  blsp_pkg::op_t f_op;
  logic [CB-1:0] f_dist_x;
  logic [CB-1:0] f_dist_y;
  logic          f_x_neg;
  logic          f_y_neg;

  logic [QW-1:0] q_wr_data;
  logic [QW-1:0] q_rd_data;
  logic          q_valid;
  logic          q_pop;

  blsp_pkg::op_t q_op;
  logic [CB-1:0] q_start_x;
  logic [CB-1:0] q_start_y;
  logic [CB-1:0] q_dist_x;
  logic [CB-1:0] q_dist_y;
  logic          q_x_neg;
  logic          q_y_neg;

  // Classify items and take the axis distances.
  blsp_front #(.COORD_BITS(CB)) u_front (
    .operation (operation),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .op        (f_op),
    .dist_x    (f_dist_x),
    .dist_y    (f_dist_y),
    .x_neg     (f_x_neg),
    .y_neg     (f_y_neg)
  );

  assign q_wr_data = {f_op, start_x, start_y, f_dist_x, f_dist_y, f_x_neg, f_y_neg};

  // Queue items between front and back.
  blsp_queue #(.WIDTH(QW), .DEPTH(blsp_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (q_wr_data),
    .full     (full),
    .rd_en    (q_pop),
    .rd_data  (q_rd_data),
    .rd_valid (q_valid)
  );

  assign q_op      = blsp_pkg::op_t'(q_rd_data[QW-1]);
  assign q_start_x = q_rd_data[4*CB+1:3*CB+2];
  assign q_start_y = q_rd_data[3*CB+1:2*CB+2];
  assign q_dist_x  = q_rd_data[2*CB+1:CB+2];
  assign q_dist_y  = q_rd_data[CB+1:2];
  assign q_x_neg   = q_rd_data[1];
  assign q_y_neg   = q_rd_data[0];

  // Step the line and hold the result.
  blsp_back #(.COORD_BITS(CB)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_op),
    .q_start_x  (q_start_x),
    .q_start_y  (q_start_y),
    .q_dist_x   (q_dist_x),
    .q_dist_y   (q_dist_y),
    .q_x_neg    (q_x_neg),
    .q_y_neg    (q_y_neg),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

endmodule

`default_nettype wire

FILE: hdl/blsp_checker.sv
`default_nettype none
`include "assert_macros.svh"

module blsp_checker #(
  parameter int COORD_BITS = blsp_pkg::COORD_BITS_DEFAULT
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  push,
  input wire logic                  full,
  input wire logic                  empty,
  input wire logic                  pop,
  input wire logic [COORD_BITS-1:0] pixel_x,
  input wire logic [COORD_BITS-1:0] pixel_y,
  input wire logic                  last_pixel
);

  // Reset leaves no result and room for items.
  `ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, empty && !full)

  // The queue only fills from accepted items.
  `ASSERT_NEXT(a_full_needs_push, clk, rst, !full && !push, !full)

  // A waiting result stays until taken.
  `ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty)

  // A waiting result keeps its value.
  `ASSERT_NEXT(a_result_stable, clk, rst, !empty && !pop,
    $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel))

endmodule

bind bresenham_line_stepper blsp_checker #(.COORD_BITS(COORD_BITS)) u_blsp_checker (
  .clk        (clk),
  .rst        (rst),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .pixel_x    (pixel_x),
  .pixel_y    (pixel_y),
  .last_pixel (last_pixel)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CW = blsp_pkg::COORD_BITS_DEFAULT;
  localparam int CMAX = (1 << CW) - 1;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          last;
  } pixel_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          full;
  logic          operation = blsp_pkg::OP_LOAD;
  logic [CW-1:0] start_x = '0;
  logic [CW-1:0] start_y = '0;
  logic [CW-1:0] end_x = '0;
  logic [CW-1:0] end_y = '0;
  logic          empty;
  logic          pop = 1'b0;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic          last_pixel;

  // Line state mirrored from the block
  logic [CW-1:0]        pen_x, pen_y;
  logic [CW-1:0]        major_len, minor_len;
  logic [CW:0]          pixels_left;
  logic signed [CW+2:0] decision;
  logic                 x_down, y_down, steep;

  pixel_t expected_pixels[$];
  pixel_t head_pixel;
  int     mismatches = 0;
  int     items_sent = 0;
  bit     steady = 1'b0;

  bresenham_line_stepper #(.COORD_BITS(CW)) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .empty      (empty),
    .pop        (pop),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bound the run in case the block hangs
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Advance the mirrored line state for one accepted item
  function automatic void predict_pixel(input blsp_pkg::op_t op,
                                        input logic [CW-1:0] sx, sy, ex, ey);
    logic [CW-1:0] dx, dy;
    if (op == blsp_pkg::OP_LOAD) begin
      x_down = ex < sx;
      y_down = ey < sy;
      dx = x_down ? sx - ex : ex - sx;
      dy = y_down ? sy - ey : ey - sy;
      steep = dy > dx;
      major_len = steep ? dy : dx;
      minor_len = steep ? dx : dy;
      decision = {2'b00, minor_len, 1'b0} - {3'b000, major_len};
      pen_x = sx;
      pen_y = sy;
      pixels_left = {1'b0, major_len};
    end else if (pixels_left != 0) begin
      expected_pixels.push_back('{x: pen_x, y: pen_y, last: pixels_left == 1});
      // Take the minor step first when the decision term is positive
      if (decision > 0) begin
        if (steep) pen_x = x_down ? pen_x - 1'b1 : pen_x + 1'b1;
        else pen_y = y_down ? pen_y - 1'b1 : pen_y + 1'b1;
        decision = decision - {2'b00, major_len, 1'b0};
      end
      if (steep) pen_y = y_down ? pen_y - 1'b1 : pen_y + 1'b1;
      else pen_x = x_down ? pen_x - 1'b1 : pen_x + 1'b1;
      decision = decision + {2'b00, minor_len, 1'b0};
      pixels_left = pixels_left - 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input pixel_t want, input pixel_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
               $realtime, what, want.x, want.y, want.last, got.x, got.y, got.last);
  endtask

  // Check each popped pixel and drive pop with random stalls
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel", '0, {pixel_x, pixel_y, last_pixel});
        end else begin
          head_pixel = expected_pixels.pop_front();
          if (pixel_x !== head_pixel.x || pixel_y !== head_pixel.y ||
              last_pixel !== head_pixel.last)
            report_mismatch("pixel mismatch", head_pixel, {pixel_x, pixel_y, last_pixel});
        end
      end
      pop <= steady || ($urandom_range(0, 99) >= 8);
    end
  end

  // Send one item and update the prediction once it is taken
  task automatic send_item(input blsp_pkg::op_t op, input logic [CW-1:0] sx = '0, sy = '0,
                           ex = '0, ey = '0);
    while (!steady && $urandom_range(0, 99) < 8) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    operation <= op;
    start_x   <= sx;
    start_y   <= sy;
    end_x     <= ex;
    end_y     <= ey;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_pixel(op, sx, sy, ex, ey);
    items_sent++;
  endtask

  task automatic send_steps(input int count);
    repeat (count) send_item(blsp_pkg::OP_STEP, CW'($urandom), CW'($urandom),
                             CW'($urandom), CW'($urandom));
  endtask

  function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] c, input int span);
    int d;
    d = $urandom_range(0, span);
    if ($urandom_range(0, 1) == 1 && int'(c) >= d) return CW'(int'(c) - d);
    if (int'(c) + d <= CMAX) return CW'(int'(c) + d);
    return CW'(int'(c) - d);
  endfunction

  // Load one random line and step through it, with some noise mixed in
  task automatic send_random_line();
    logic [CW-1:0] sx, sy;
    int            pick;
    sx = $urandom_range(0, 9) == 0 ? CW'($urandom_range(0, 1) ? CMAX : 0)
                                   : CW'($urandom_range(0, CMAX));
    sy = $urandom_range(0, 9) == 0 ? CW'($urandom_range(0, 1) ? CMAX : 0)
                                   : CW'($urandom_range(0, CMAX));
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      send_item(blsp_pkg::OP_LOAD, sx, sy, near_coord(sx, 12), near_coord(sy, 12));
      send_steps(major_len + $urandom_range(0, 2));
    end else if (pick < 90) begin
      // Cut the line short and let the next load replace it
      send_item(blsp_pkg::OP_LOAD, sx, sy, near_coord(sx, 40), near_coord(sy, 40));
      send_steps($urandom_range(0, major_len));
    end else if (pick < 97) begin
      send_item(blsp_pkg::OP_LOAD, sx, sy, CW'($urandom_range(0, CMAX)),
                CW'($urandom_range(0, CMAX)));
      send_steps($urandom_range(1, 5));
    end else begin
      send_steps($urandom_range(1, 3));
    end
  endtask

  task automatic test_idle_step();
    send_item(blsp_pkg::OP_STEP, CW'(CMAX), CW'(CMAX), CW'(CMAX), CW'(CMAX));
  endtask

  task automatic test_zero_length();
    send_item(blsp_pkg::OP_LOAD, 12'd1234, 12'd2345, 12'd1234, 12'd2345);
    send_item(blsp_pkg::OP_STEP);
  endtask

  // Load corner to corner and take two pixels; the next load replaces the line
  task automatic test_extremes();
    send_item(blsp_pkg::OP_LOAD, '0, CW'(CMAX), CW'(CMAX), '0);
    send_steps(2);
  endtask

  // Walk a short line into every octant; step once past the end of the last
  task automatic test_octants();
    int ddx[8] = '{2, 1, -1, -2, -2, -1, 1, 2};
    int ddy[8] = '{1, 2, 2, 1, -1, -2, -2, -1};
    for (int i = 0; i < 8; i++) begin
      send_item(blsp_pkg::OP_LOAD, 12'd100, 12'd100, CW'(100 + ddx[i]), CW'(100 + ddy[i]));
      send_steps(2);
    end
    send_item(blsp_pkg::OP_STEP);
  endtask

  task automatic test_random_lines(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) send_random_line();
  endtask

  // Hold off the sender until every pixel has come out
  task automatic test_drain_pause();
    push <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    send_random_line();
  endtask

  task automatic test_steady_stream(input int count);
    steady = 1'b1;
    test_random_lines(count);
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_idle_step();
    test_zero_length();
    test_extremes();
    test_octants();
    test_random_lines(250);
    test_drain_pause();
    test_steady_stream(100);
    test_random_lines(250);

    // Drain and watch for stray pixels
    push <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
